// ===== rtl/uldt_pkg.sv =====
// Shared types, constants and the month start table for the UTC to local date pipeline.
package uldt_pkg;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FIELD = 2'd1,
        ST_YEAR  = 2'd2
    } t_status;

    localparam int unsigned PIPE_LATENCY     = 7;

    localparam int unsigned YEAR_FIRST       = 2000;
    localparam int unsigned YEAR_LAST        = 2099;
    localparam int unsigned YEAR_BASE        = 1970;
    localparam int unsigned YEAR_CYCLE_BASE  = 1972;

    localparam int unsigned SEC_PER_DAY      = 86400;
    localparam int unsigned SEC_PER_HOUR     = 3600;
    localparam int unsigned SEC_PER_MIN      = 60;
    localparam int unsigned YEAR_DAYS        = 365;
    localparam int unsigned CYCLE_DAYS       = 1461;
    localparam int unsigned WEEK_DAYS        = 7;
    localparam int unsigned EPOCH_TO_MAR     = 59;
    localparam int unsigned DAYS_TO_1972_MAR = 790;

    // Reciprocals, exact over the operand ranges that occur.
    localparam int unsigned HOUR_RECIP       = 1193047;
    localparam int unsigned HOUR_SHIFT       = 32;
    localparam int unsigned MIN_RECIP        = 4370;
    localparam int unsigned MIN_SHIFT        = 18;
    localparam int unsigned CYC_RECIP        = 45934;
    localparam int unsigned CYC_SHIFT        = 26;
    localparam int unsigned WEEK_RECIP       = 74899;
    localparam int unsigned WEEK_SHIFT       = 19;

    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [15:0] days;
        logic [16:0] tod_utc;
        logic [16:0] tod_local;
        logic [1:0]  day_adj;
    } t_front;

    // First day of each month in a year that starts on the first of March.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] res;
        unique case (mp)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd61;
            4'd3:    res = 9'd92;
            4'd4:    res = 9'd122;
            4'd5:    res = 9'd153;
            4'd6:    res = 9'd184;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd245;
            4'd9:    res = 9'd275;
            4'd10:   res = 9'd306;
            4'd11:   res = 9'd337;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/utc_date_to_local_rtc_fields.sv =====
// Top level: UTC date and time to Unix seconds and local calendar fields.
// Pipeline: seven register stages, from the field checks in the front to the output registers;
// a word taken at a clock edge moves through them in order to the result ports.
// Throughput: one word per cycle; busy stays low, as every stage advances each cycle.
// The stage count is set by the reciprocal multiplies and the month search of the date split.
// Synchronous active-low reset empties the pipeline and clears the zone offset to zero.
module utc_date_to_local_rtc_fields import uldt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [13:0]        i_year,
    input  logic [3:0]         i_month,
    input  logic [5:0]         i_day,
    input  logic [5:0]         i_hour,
    input  logic [5:0]         i_minute,
    input  logic [5:0]         i_second,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic signed [16:0] i_cfg_data,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic [31:0]        o_unix_seconds,
    output logic [11:0]        o_local_year,
    output logic [3:0]         o_local_month,
    output logic [4:0]         o_local_day,
    output logic [2:0]         o_local_weekday,
    output logic [4:0]         o_local_hour,
    output logic [5:0]         o_local_minute,
    output logic [5:0]         o_local_second
);

    logic signed [16:0] r_zone_offset;
    t_front             front;
    t_status            date_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_offset <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_zone_offset <= i_cfg_data;
        end
    end

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    uldt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start && !o_busy),
        .i_year        (i_year),
        .i_month       (i_month),
        .i_day         (i_day),
        .i_hour        (i_hour),
        .i_minute      (i_minute),
        .i_second      (i_second),
        .i_zone_offset (r_zone_offset),
        .o_front       (front)
    );

    uldt_date u_date (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_front        (front),
        .o_valid        (o_strobe),
        .o_status       (date_status),
        .o_unix_seconds (o_unix_seconds),
        .o_year         (o_local_year),
        .o_month        (o_local_month),
        .o_day          (o_local_day),
        .o_weekday      (o_local_weekday)
    );

    uldt_clock u_clock (
        .i_clk       (i_clk),
        .i_tod_local (front.tod_local),
        .i_ok        (front.status == ST_OK),
        .o_hour      (o_local_hour),
        .o_minute    (o_local_minute),
        .o_second    (o_local_second)
    );

    assign o_status = date_status;

    a_strobe_follows_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_start, PIPE_LATENCY))
        else $error("result word without a start seven cycles earlier");

    a_reject_clears_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && date_status != ST_OK) |->
            (o_unix_seconds == 32'd0 && o_local_year == 12'd0 && o_local_month == 4'd0
             && o_local_day == 5'd0 && o_local_weekday == 3'd0 && o_local_hour == 5'd0
             && o_local_minute == 6'd0 && o_local_second == 6'd0))
        else $error("rejected word carries non-zero fields");

    a_local_fields_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && date_status == ST_OK) |->
            (o_local_month >= 4'd1 && o_local_month <= 4'd12 && o_local_day >= 5'd1
             && o_local_weekday >= 3'd1 && o_local_weekday <= 3'd7
             && o_local_hour <= 5'd23 && o_local_minute <= 6'd59
             && o_local_second <= 6'd59
             && o_local_year >= 12'd1999 && o_local_year <= 12'd2100))
        else $error("local field out of range on an accepted word");

endmodule

// ===== rtl/uldt_front.sv =====
// Front stages: field checks, day count since the epoch and local time of day.
module uldt_front import uldt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [13:0]        i_year,
    input  logic [3:0]         i_month,
    input  logic [5:0]         i_day,
    input  logic [5:0]         i_hour,
    input  logic [5:0]         i_minute,
    input  logic [5:0]         i_second,
    input  logic signed [16:0] i_zone_offset,
    output t_front             o_front
);

    logic               field_bad;
    logic               year_bad;
    logic               mar;
    logic [3:0]         mshift;
    t_status            n_s1_status;
    logic [7:0]         n_s1_yy;
    logic [8:0]         n_s1_doy;
    logic [16:0]        n_s1_tod;

    logic               r_s1_valid;
    t_status            r_s1_status;
    logic [7:0]         r_s1_yy;
    logic [8:0]         r_s1_doy;
    logic [16:0]        r_s1_tod;

    logic [8:0]         n_leap;
    logic [15:0]        n_days;
    logic signed [18:0] n_tod_raw;
    logic [16:0]        n_tod_local;
    logic [1:0]         n_day_adj;

    t_front             r_front;

    always_comb begin
        field_bad = (i_month < 4'd1) || (i_month > 4'd12) || (i_day == 6'd0)
                 || (i_day > 6'd31) || (i_hour > 6'd23) || (i_minute > 6'd59)
                 || (i_second > 6'd60);
        year_bad  = (i_year < 14'(YEAR_FIRST)) || (i_year > 14'(YEAR_LAST));
        priority if (field_bad) begin
            n_s1_status = ST_FIELD;
        end else if (year_bad) begin
            n_s1_status = ST_YEAR;
        end else begin
            n_s1_status = ST_OK;
        end
        mar      = (i_month <= 4'd2);
        mshift   = mar ? i_month + 4'd9 : i_month - 4'd3;
        n_s1_yy  = 8'(i_year - 14'(YEAR_BASE) - {13'd0, mar});
        n_s1_doy = month_start(mshift) + {3'd0, i_day} - 9'd1;
        n_s1_tod = 17'(i_hour) * 17'(SEC_PER_HOUR) + 17'(i_minute) * 17'(SEC_PER_MIN)
                 + 17'(i_second);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_status <= n_s1_status;
        r_s1_yy     <= n_s1_yy;
        r_s1_doy    <= n_s1_doy;
        r_s1_tod    <= n_s1_tod;
    end

    // The offset moves the time of day by less than one day either way.
    always_comb begin
        n_leap    = ({1'b0, r_s1_yy} + 9'd2) >> 2;
        n_days    = 16'(r_s1_yy) * 16'(YEAR_DAYS) + 16'(n_leap) + 16'(EPOCH_TO_MAR)
                  + 16'(r_s1_doy);
        n_tod_raw = $signed({2'b00, r_s1_tod})
                  + $signed({{2{i_zone_offset[16]}}, i_zone_offset});
        priority if (n_tod_raw < 0) begin
            n_tod_local = 17'(n_tod_raw + 19'sd86400);
            n_day_adj   = 2'b11;
        end else if (n_tod_raw >= 19'sd86400) begin
            n_tod_local = 17'(n_tod_raw - 19'sd86400);
            n_day_adj   = 2'b01;
        end else begin
            n_tod_local = 17'(n_tod_raw);
            n_day_adj   = 2'b00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.valid <= 1'b0;
        end else begin
            r_front.valid <= r_s1_valid;
        end
        r_front.status    <= r_s1_status;
        r_front.days      <= n_days;
        r_front.tod_utc   <= r_s1_tod;
        r_front.tod_local <= n_tod_local;
        r_front.day_adj   <= n_day_adj;
    end

    assign o_front = r_front;

endmodule

// ===== rtl/uldt_date.sv =====
// Date stages: Unix seconds, local calendar date and weekday from the day count.
module uldt_date import uldt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_front      i_front,
    output logic        o_valid,
    output t_status     o_status,
    output logic [31:0] o_unix_seconds,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [2:0]  o_weekday
);

    logic [15:0] n_s3_zl;
    logic [15:0] n_s3_u;
    logic        r_s3_valid;
    t_status     r_s3_status;
    logic [31:0] r_s3_prod;
    logic [16:0] r_s3_tod_utc;
    logic [15:0] r_s3_zl;
    logic [15:0] r_s3_u;

    logic [31:0] w_cyc_prod;
    logic [32:0] w_week_prod;
    logic        r_s4_valid;
    t_status     r_s4_status;
    logic [31:0] r_s4_utc;
    logic [4:0]  r_s4_cyc;
    logic [12:0] r_s4_q7;
    logic [15:0] r_s4_u;
    logic [15:0] r_s4_zl;

    logic        r_s5_valid;
    t_status     r_s5_status;
    logic [31:0] r_s5_utc;
    logic [4:0]  r_s5_cyc;
    logic [10:0] r_s5_r;
    logic [2:0]  r_s5_wmod;

    logic [1:0]  n_yoe;
    logic        r_s6_valid;
    t_status     r_s6_status;
    logic [31:0] r_s6_utc;
    logic [8:0]  r_s6_doy;
    logic [6:0]  r_s6_yq;
    logic [2:0]  r_s6_wd;

    logic [3:0]  n_mp;
    logic        n_ok;
    logic        r_valid;
    t_status     r_status;
    logic [31:0] r_unix_seconds;
    logic [11:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [2:0]  r_weekday;

    always_comb begin
        n_s3_zl = i_front.days + {{14{i_front.day_adj[1]}}, i_front.day_adj};
        n_s3_u  = n_s3_zl - 16'(DAYS_TO_1972_MAR);
    end

    assign w_cyc_prod  = {16'd0, r_s3_u} * 32'(CYC_RECIP);
    assign w_week_prod = {17'd0, r_s3_zl} * 33'(WEEK_RECIP);

    always_comb begin
        priority if (r_s5_r >= 11'(3 * YEAR_DAYS)) begin
            n_yoe = 2'd3;
        end else if (r_s5_r >= 11'(2 * YEAR_DAYS)) begin
            n_yoe = 2'd2;
        end else if (r_s5_r >= 11'(YEAR_DAYS)) begin
            n_yoe = 2'd1;
        end else begin
            n_yoe = 2'd0;
        end
    end

    always_comb begin
        n_mp = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (r_s6_doy >= month_start(4'(k))) begin
                n_mp = 4'(k);
            end
        end
        n_ok = (r_s6_status == ST_OK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_s3_valid <= i_front.valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
            r_s6_valid <= r_s5_valid;
            r_valid    <= r_s6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_status  <= i_front.status;
        r_s3_prod    <= {16'd0, i_front.days} * 32'(SEC_PER_DAY);
        r_s3_tod_utc <= i_front.tod_utc;
        r_s3_zl      <= n_s3_zl;
        r_s3_u       <= n_s3_u;

        r_s4_status  <= r_s3_status;
        r_s4_utc     <= r_s3_prod + {15'd0, r_s3_tod_utc};
        r_s4_cyc     <= w_cyc_prod[CYC_SHIFT +: 5];
        r_s4_q7      <= w_week_prod[WEEK_SHIFT +: 13];
        r_s4_u       <= r_s3_u;
        r_s4_zl      <= r_s3_zl;

        r_s5_status  <= r_s4_status;
        r_s5_utc     <= r_s4_utc;
        r_s5_cyc     <= r_s4_cyc;
        r_s5_r       <= 11'(r_s4_u - 16'(r_s4_cyc) * 16'(CYCLE_DAYS));
        r_s5_wmod    <= 3'(r_s4_zl - 16'(r_s4_q7) * 16'(WEEK_DAYS));

        r_s6_status  <= r_s5_status;
        r_s6_utc     <= r_s5_utc;
        r_s6_doy     <= 9'(r_s5_r - 11'(n_yoe) * 11'(YEAR_DAYS));
        r_s6_yq      <= {r_s5_cyc, n_yoe};
        r_s6_wd      <= (r_s5_wmod <= 3'd3) ? r_s5_wmod + 3'd4 : r_s5_wmod - 3'd3;

        r_status       <= r_s6_status;
        r_unix_seconds <= n_ok ? r_s6_utc : 32'd0;
        r_year         <= n_ok ? 12'(12'(YEAR_CYCLE_BASE) + {5'd0, r_s6_yq}
                                     + {11'd0, (n_mp >= 4'd10)}) : 12'd0;
        r_month        <= n_ok ? ((n_mp < 4'd10) ? n_mp + 4'd3 : n_mp - 4'd9) : 4'd0;
        r_day          <= n_ok ? 5'(r_s6_doy - month_start(n_mp) + 9'd1) : 5'd0;
        r_weekday      <= n_ok ? r_s6_wd : 3'd0;
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_unix_seconds = r_unix_seconds;
    assign o_year         = r_year;
    assign o_month        = r_month;
    assign o_day          = r_day;
    assign o_weekday      = r_weekday;

endmodule

// ===== rtl/uldt_clock.sv =====
// Clock stages: local hour, minute and second from the local second of the day.
module uldt_clock import uldt_pkg::*; (
    input  logic        i_clk,
    input  logic [16:0] i_tod_local,
    input  logic        i_ok,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);

    logic [37:0] w_hour_prod;
    logic [24:0] w_min_prod;

    logic [16:0] r_s3_tod;
    logic [4:0]  r_s3_hour;
    logic [11:0] r_s4_rem;
    logic [4:0]  r_s4_hour;
    logic [11:0] r_s5_rem;
    logic [5:0]  r_s5_min;
    logic [4:0]  r_s5_hour;
    logic [5:0]  r_s6_sec;
    logic [5:0]  r_s6_min;
    logic [4:0]  r_s6_hour;
    logic [3:0]  r_ok;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;
    logic [5:0]  r_second;

    assign w_hour_prod = {21'd0, i_tod_local} * 38'(HOUR_RECIP);
    assign w_min_prod  = {13'd0, r_s4_rem} * 25'(MIN_RECIP);

    always_ff @(posedge i_clk) begin
        r_s3_tod  <= i_tod_local;
        r_s3_hour <= w_hour_prod[HOUR_SHIFT +: 5];

        r_s4_rem  <= 12'(r_s3_tod - 17'(r_s3_hour) * 17'(SEC_PER_HOUR));
        r_s4_hour <= r_s3_hour;

        r_s5_rem  <= r_s4_rem;
        r_s5_min  <= w_min_prod[MIN_SHIFT +: 6];
        r_s5_hour <= r_s4_hour;

        r_s6_sec  <= 6'(r_s5_rem - 12'(r_s5_min) * 12'(SEC_PER_MIN));
        r_s6_min  <= r_s5_min;
        r_s6_hour <= r_s5_hour;

        r_ok      <= {r_ok[2:0], i_ok};

        r_hour    <= r_ok[3] ? r_s6_hour : 5'd0;
        r_minute  <= r_ok[3] ? r_s6_min : 6'd0;
        r_second  <= r_ok[3] ? r_s6_sec : 6'd0;
    end

    assign o_hour   = r_hour;
    assign o_minute = r_minute;
    assign o_second = r_second;

endmodule
